[rtl/sfsg_pkg.sv]
`timescale 1ns / 1ps

package sfsg_pkg;

    // Frequency limits in kHz
    localparam int unsigned FreqMinLo = 20;
    localparam int unsigned FreqMaxLo = 30;
    localparam int unsigned FreqHi    = 999;

    // Half-period divisor scale: clock_hz / (khz * HalfScale)
    localparam int unsigned HalfScale = 2000;

    // Field widths
    localparam int unsigned ClkW    = 29;
    localparam int unsigned TallyW  = 8;
    localparam int unsigned TickW   = 32;
    localparam int unsigned KhzW    = 10;
    localparam int unsigned ReqW    = 16;
    localparam int unsigned SampleW = 16;
    localparam int unsigned HalfW   = 14;
    localparam int unsigned DivisW  = 21;
    localparam int unsigned RemW    = DivisW + 1;

    // Divider runs one quotient bit per dividend bit
    localparam int unsigned DivSteps = ClkW;
    localparam int unsigned DivCntW  = $clog2(DivSteps);

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_CLOCK_HZ         = 2'd0,
        CFG_TOGGLES_PER_STEP = 2'd1,
        CFG_PAUSE_TICKS      = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic [ClkW-1:0]   ClockHzRst  = ClkW'(240000000);
    localparam logic [TallyW-1:0] TogglesRst  = TallyW'(20);
    localparam logic [TickW-1:0]  PauseRst    = TickW'(24000000);

    // Controller to datapath
    typedef struct packed {
        logic accept_en;   // item may be taken
        logic mul_load;    // form divisor from current frequency
        logic div_step;    // one divider iteration
        logic div_last;    // final iteration, write half-period
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_taken;  // item accepted this cycle
        logic need_div;    // accepted item needs a new half-period
    } t_ctrl_sts;

endpackage

[rtl/sfsg_if.sv]
`timescale 1ns / 1ps

// Input item channel
interface sfsg_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [sfsg_pkg::ReqW-1:0]    min_khz;
    logic [sfsg_pkg::ReqW-1:0]    max_khz;
    logic                        burst_active;
    logic [sfsg_pkg::SampleW-1:0] current_sample;

    modport source (output valid, kind, min_khz, max_khz, burst_active, current_sample,
                    input ready);
    modport sink   (input valid, kind, min_khz, max_khz, burst_active, current_sample,
                    output ready);
endinterface

// Result item channel
interface sfsg_out_if;
    logic                        valid;
    logic                        ready;
    logic                        gate_level;
    logic                        gate_enable;
    logic                        sweep_running;
    logic                        report_valid;
    logic [sfsg_pkg::KhzW-1:0]    report_khz;
    logic [sfsg_pkg::SampleW-1:0] report_current;
    logic                        sweep_done;

    modport source (output valid, gate_level, gate_enable, sweep_running, report_valid,
                    report_khz, report_current, sweep_done, input ready);
    modport sink   (input valid, gate_level, gate_enable, sweep_running, report_valid,
                    report_khz, report_current, sweep_done, output ready);
endinterface

// Configuration write channel
interface sfsg_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sfsg_pkg::CfgIdxW-1:0] index;
    logic [sfsg_pkg::TickW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/sfsg_ctrl.sv]
`timescale 1ns / 1ps

module sfsg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfsg_pkg::t_ctrl_sts   i_sts,
    output sfsg_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_READY = 3'b001,
        ST_MUL   = 3'b010,
        ST_DIV   = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [sfsg_pkg::DivCntW-1:0]  r_cnt, n_cnt;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_READY: begin
                o_cmd.accept_en = 1'b1;
                if (i_sts.item_taken && i_sts.need_div) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == sfsg_pkg::DivCntW'(sfsg_pkg::DivSteps - 1)) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = ST_READY;
                end
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[rtl/sfsg_dp.sv]
`timescale 1ns / 1ps

module sfsg_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfsg_pkg::t_ctrl_cmd   i_cmd,
    output sfsg_pkg::t_ctrl_sts   o_sts,
    sfsg_in_if.sink               i_in,
    sfsg_out_if.source            o_out,
    sfsg_cfg_if.sink              i_cfg
);

    // Clamp a requested frequency into lo..FreqHi
    function automatic logic [sfsg_pkg::KhzW-1:0] clamp_khz(
        input logic [sfsg_pkg::ReqW-1:0] v,
        input logic [sfsg_pkg::ReqW-1:0] lo
    );
        logic [sfsg_pkg::ReqW-1:0] t;
        t = v;
        if (v < lo) begin
            t = lo;
        end else if (v > sfsg_pkg::ReqW'(sfsg_pkg::FreqHi)) begin
            t = sfsg_pkg::ReqW'(sfsg_pkg::FreqHi);
        end
        return t[sfsg_pkg::KhzW-1:0];
    endfunction

    // Configuration
    logic [sfsg_pkg::ClkW-1:0]   r_clock_hz;
    logic [sfsg_pkg::TallyW-1:0] r_tps;
    logic [sfsg_pkg::TickW-1:0]  r_pause_ticks;

    // Sweep state
    logic                        r_active, n_active;
    logic                        r_level, n_level;
    logic                        r_drive_on, n_drive_on;
    logic [sfsg_pkg::KhzW-1:0]   r_freq_now, n_freq_now;
    logic [sfsg_pkg::KhzW-1:0]   r_freq_last, n_freq_last;
    logic [sfsg_pkg::TallyW-1:0] r_tally, n_tally;
    logic [sfsg_pkg::TickW-1:0]  r_elapsed, n_elapsed;
    logic [sfsg_pkg::HalfW-1:0]  r_half;
    logic [sfsg_pkg::TickW-1:0]  r_pause_left, n_pause_left;

    // Divider
    logic [sfsg_pkg::DivisW-1:0] r_divisor;
    logic [sfsg_pkg::ClkW-1:0]   r_dividend;
    logic [sfsg_pkg::RemW-1:0]   r_rem, n_rem, rem_shift;
    logic [sfsg_pkg::HalfW-1:0]  r_quot, n_quot;
    logic                        q_bit;

    // Result
    logic                        r_out_valid;
    logic                        r_rep_valid, n_rep_valid;
    logic [sfsg_pkg::KhzW-1:0]   r_rep_khz, n_rep_khz;
    logic [sfsg_pkg::SampleW-1:0] r_rep_cur, n_rep_cur;
    logic                        r_done, n_done;

    logic                        take;
    logic                        need_div;

    // Handshakes
    assign i_in.ready  = i_cmd.accept_en && (!r_out_valid || o_out.ready);
    assign take        = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_sts.item_taken = take;
    assign o_sts.need_div   = need_div;

    // Effect of one item on the sweep state
    always_comb begin
        n_active     = r_active;
        n_level      = r_level;
        n_drive_on   = r_drive_on;
        n_freq_now   = r_freq_now;
        n_freq_last  = r_freq_last;
        n_tally      = r_tally;
        n_elapsed    = r_elapsed;
        n_pause_left = r_pause_left;
        n_rep_valid  = 1'b0;
        n_rep_khz    = '0;
        n_rep_cur    = '0;
        n_done       = 1'b0;
        need_div     = 1'b0;
        if (i_in.kind) begin
            // start request
            if (!r_active && !i_in.burst_active) begin
                n_freq_now   = clamp_khz(i_in.min_khz, sfsg_pkg::ReqW'(sfsg_pkg::FreqMinLo));
                n_freq_last  = clamp_khz(i_in.max_khz, sfsg_pkg::ReqW'(sfsg_pkg::FreqMaxLo));
                n_tally      = '0;
                n_elapsed    = '0;
                n_pause_left = '0;
                n_drive_on   = 1'b1;
                n_active     = 1'b1;
                need_div     = 1'b1;
            end
        end else if (r_active) begin
            if (r_pause_left != '0) begin
                // pause countdown
                n_pause_left = r_pause_left - 1'b1;
                if (n_pause_left == '0) begin
                    n_level   = ~r_level;
                    n_elapsed = '0;
                    n_tally   = r_tally + 1'b1;
                end
            end else begin
                // half-period timing, saturating count
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                if (n_elapsed >= sfsg_pkg::TickW'(r_half)) begin
                    if (r_tally >= r_tps) begin
                        n_rep_valid = 1'b1;
                        n_rep_khz   = r_freq_now;
                        n_rep_cur   = i_in.current_sample;
                        n_freq_now  = r_freq_now + 1'b1;
                        n_tally     = '0;
                        if (n_freq_now > r_freq_last) begin
                            n_active   = 1'b0;
                            n_drive_on = 1'b0;
                            n_done     = 1'b1;
                        end else begin
                            need_div = 1'b1;
                            if (r_pause_ticks == '0) begin
                                n_level   = ~r_level;
                                n_elapsed = '0;
                                n_tally   = sfsg_pkg::TallyW'(1);
                            end else begin
                                n_pause_left = r_pause_ticks;
                            end
                        end
                    end else begin
                        n_level   = ~r_level;
                        n_elapsed = '0;
                        n_tally   = r_tally + 1'b1;
                    end
                end
            end
        end
    end

    // Restoring divider iteration
    always_comb begin
        rem_shift = {r_rem[sfsg_pkg::RemW-2:0], r_dividend[sfsg_pkg::ClkW-1]};
        q_bit     = (rem_shift >= {1'b0, r_divisor});
        n_rem     = q_bit ? (rem_shift - {1'b0, r_divisor}) : rem_shift;
        n_quot    = {r_quot[sfsg_pkg::HalfW-2:0], q_bit};
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz    <= sfsg_pkg::ClockHzRst;
            r_tps         <= sfsg_pkg::TogglesRst;
            r_pause_ticks <= sfsg_pkg::PauseRst;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sfsg_pkg::CFG_CLOCK_HZ:         r_clock_hz    <= i_cfg.data[sfsg_pkg::ClkW-1:0];
                sfsg_pkg::CFG_TOGGLES_PER_STEP: r_tps         <= i_cfg.data[sfsg_pkg::TallyW-1:0];
                sfsg_pkg::CFG_PAUSE_TICKS:      r_pause_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Sweep state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_level      <= 1'b0;
            r_drive_on   <= 1'b0;
            r_freq_now   <= '0;
            r_freq_last  <= '0;
            r_tally      <= '0;
            r_elapsed    <= '0;
            r_half       <= '0;
            r_pause_left <= '0;
        end else begin
            if (take) begin
                r_active     <= n_active;
                r_level      <= n_level;
                r_drive_on   <= n_drive_on;
                r_freq_now   <= n_freq_now;
                r_freq_last  <= n_freq_last;
                r_tally      <= n_tally;
                r_elapsed    <= n_elapsed;
                r_pause_left <= n_pause_left;
            end
            if (i_cmd.div_last) begin
                r_half <= n_quot;
            end
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_divisor  <= sfsg_pkg::DivisW'(r_freq_now * sfsg_pkg::DivisW'(sfsg_pkg::HalfScale));
            r_dividend <= r_clock_hz;
            r_rem      <= '0;
            r_quot     <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[sfsg_pkg::ClkW-2:0], 1'b0};
            r_rem      <= n_rem;
            r_quot     <= n_quot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rep_valid <= n_rep_valid;
            r_rep_khz   <= n_rep_khz;
            r_rep_cur   <= n_rep_cur;
            r_done      <= n_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.gate_level     = r_level;
    assign o_out.gate_enable    = r_drive_on;
    assign o_out.sweep_running  = r_active;
    assign o_out.report_valid   = r_rep_valid;
    assign o_out.report_khz     = r_rep_khz;
    assign o_out.report_current = r_rep_cur;
    assign o_out.sweep_done     = r_done;

endmodule

[rtl/stepped_frequency_sweep_generator_unit.sv]
`timescale 1ns / 1ps
// Every item's result is registered and offered in the cycle after the item is taken.
// Throughput: tick items and refused starts one per cycle while the result is not stalled;
// an accepted start or a frequency step holds off the next item while the divisor is formed
// and then for the 29 iterations of the shared bit-serial half-period divider.
// Reset (synchronous, active low): sweep idle, gate low, registers to defaults.

module stepped_frequency_sweep_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfsg_in_if.sink     i_in,
    sfsg_out_if.source  o_out,
    sfsg_cfg_if.sink    i_cfg
);

    sfsg_pkg::t_ctrl_cmd cmd;
    sfsg_pkg::t_ctrl_sts sts;

    sfsg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sfsg_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule

[rtl/sfsg_chk.sv]
`timescale 1ns / 1ps

module sfsg_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         gate_enable,
    input logic                         sweep_running,
    input logic                         report_valid,
    input logic [sfsg_pkg::KhzW-1:0]    report_khz,
    input logic [sfsg_pkg::SampleW-1:0] report_current,
    input logic                         sweep_done
);

    // A finished sweep shows the drive off and the sweep stopped, with a report
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && sweep_done |-> report_valid && !sweep_running && !gate_enable)
        else $error("sweep_done without stop and report");

    // Drive enable follows the running flag
    a_enable_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> gate_enable == sweep_running)
        else $error("gate_enable differs from sweep_running");

    // No report fields without a report
    a_rep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !report_valid |-> report_khz == '0 && report_current == '0)
        else $error("report fields set without report");

    // Reported frequency lies in the clamped range
    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && report_valid |->
            report_khz >= sfsg_pkg::KhzW'(sfsg_pkg::FreqMinLo) &&
            report_khz <= sfsg_pkg::KhzW'(sfsg_pkg::FreqHi))
        else $error("report_khz out of range");

    // A result held back stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

endmodule

bind stepped_frequency_sweep_generator_unit sfsg_chk u_sfsg_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .out_valid      (o_out.valid),
    .out_ready      (o_out.ready),
    .gate_enable    (o_out.gate_enable),
    .sweep_running  (o_out.sweep_running),
    .report_valid   (o_out.report_valid),
    .report_khz     (o_out.report_khz),
    .report_current (o_out.report_current),
    .sweep_done     (o_out.sweep_done)
);

[tb/stepped_frequency_sweep_generator_unit_test.sv]
`timescale 1ns / 1ps

module stepped_frequency_sweep_generator_unit_test;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned SettleCycles = 40;    // covers the divider hold-off
    localparam int unsigned MaxPrinted = 100;

    // One input item
    typedef struct packed {
        logic                         kind;
        logic [sfsg_pkg::ReqW-1:0]    min_khz;
        logic [sfsg_pkg::ReqW-1:0]    max_khz;
        logic                         burst;
        logic [sfsg_pkg::SampleW-1:0] cur_sample;
    } t_sweep_cmd;

    // One result item
    typedef struct packed {
        logic                         gate_level;
        logic                         gate_enable;
        logic                         sweep_running;
        logic                         report_valid;
        logic [sfsg_pkg::KhzW-1:0]    report_khz;
        logic [sfsg_pkg::SampleW-1:0] report_current;
        logic                         sweep_done;
    } t_gate_state;

    logic i_clk;
    logic i_rst_n;

    sfsg_in_if  in_if();
    sfsg_out_if out_if();
    sfsg_cfg_if cfg_if();

    stepped_frequency_sweep_generator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow registers
    logic [sfsg_pkg::ClkW-1:0]   clk_rate_hz   = sfsg_pkg::ClockHzRst;
    logic [sfsg_pkg::TallyW-1:0] toggle_target = sfsg_pkg::TogglesRst;
    logic [sfsg_pkg::TickW-1:0]  pause_len     = sfsg_pkg::PauseRst;

    // Shadow sweep state
    logic                        sw_active  = 1'b0;
    logic                        sw_level   = 1'b0;
    logic                        sw_drive   = 1'b0;
    logic [sfsg_pkg::KhzW-1:0]   sw_freq    = '0;
    logic [sfsg_pkg::KhzW-1:0]   sw_stop    = '0;
    logic [sfsg_pkg::TallyW-1:0] sw_tally   = '0;
    logic [sfsg_pkg::TickW-1:0]  sw_elapsed = '0;
    logic [sfsg_pkg::HalfW-1:0]  sw_half    = '0;
    logic [sfsg_pkg::TickW-1:0]  sw_pause   = '0;

    t_sweep_cmd  pending_cmds[$];
    t_gate_state due_gate_states[$];
    t_sweep_cmd  held_cmd;

    int unsigned queued_n     = 0;
    int unsigned accepted_n   = 0;
    int unsigned results_n    = 0;
    int unsigned mismatch_n   = 0;
    int unsigned cycle_n      = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n >= CycleLimit) begin
            $display("stepped_frequency_sweep_generator_unit regression: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (mismatch_n < MaxPrinted)
            $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                     results_n, what, got, want);
        mismatch_n++;
    endtask

    function automatic logic [sfsg_pkg::KhzW-1:0] clamp_khz(
        input logic [sfsg_pkg::ReqW-1:0] v,
        input int unsigned lo
    );
        if (v < lo) return sfsg_pkg::KhzW'(lo);
        if (v > sfsg_pkg::FreqHi) return sfsg_pkg::KhzW'(sfsg_pkg::FreqHi);
        return v[sfsg_pkg::KhzW-1:0];
    endfunction

    function automatic logic [sfsg_pkg::HalfW-1:0] half_ticks(
        input logic [sfsg_pkg::KhzW-1:0] khz
    );
        logic [31:0] divisor;
        logic [31:0] quot;
        divisor = 32'(khz) * sfsg_pkg::HalfScale;
        if (divisor == 0) return '0;
        quot = 32'(clk_rate_hz) / divisor;
        return quot[sfsg_pkg::HalfW-1:0];
    endfunction

    task automatic flip_gate();
        sw_level   = ~sw_level;
        sw_elapsed = '0;
        sw_tally   = sw_tally + 1'b1;
    endtask

    // Advance the shadow sweep by one item and queue the gate state it gives
    task automatic step_sweep(input t_sweep_cmd c);
        t_gate_state r;
        r = '0;
        if (c.kind == KIND_START) begin
            // refused while running or in burst mode
            if (!sw_active && !c.burst) begin
                sw_freq    = clamp_khz(c.min_khz, sfsg_pkg::FreqMinLo);
                sw_stop    = clamp_khz(c.max_khz, sfsg_pkg::FreqMaxLo);
                sw_tally   = '0;
                sw_elapsed = '0;
                sw_pause   = '0;
                sw_half    = half_ticks(sw_freq);
                sw_drive   = 1'b1;
                sw_active  = 1'b1;
            end
        end else if (sw_active) begin
            if (sw_pause != 0) begin
                sw_pause = sw_pause - 1'b1;
                if (sw_pause == 0) flip_gate();
            end else begin
                if (sw_elapsed != '1) sw_elapsed = sw_elapsed + 1'b1;
                if (sw_elapsed >= sfsg_pkg::TickW'(sw_half)) begin
                    if (sw_tally >= toggle_target) begin
                        // report, then step up by 1 kHz
                        r.report_valid   = 1'b1;
                        r.report_khz     = sw_freq;
                        r.report_current = c.cur_sample;
                        sw_freq  = sw_freq + 1'b1;
                        sw_tally = '0;
                        if (sw_freq > sw_stop) begin
                            sw_active    = 1'b0;
                            sw_drive     = 1'b0;
                            r.sweep_done = 1'b1;
                        end else begin
                            sw_half = half_ticks(sw_freq);
                            if (pause_len == 0) flip_gate();
                            else sw_pause = pause_len;
                        end
                    end else begin
                        flip_gate();
                    end
                end
            end
        end
        r.gate_level    = sw_level;
        r.gate_enable   = sw_drive;
        r.sweep_running = sw_active;
        due_gate_states.push_back(r);
    endtask

    // Driver: presents queued items, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                step_sweep(held_cmd);
                accepted_n++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    held_cmd              = pending_cmds.pop_front();
                    in_if.valid          <= 1'b1;
                    in_if.kind           <= held_cmd.kind;
                    in_if.min_khz        <= held_cmd.min_khz;
                    in_if.max_khz        <= held_cmd.max_khz;
                    in_if.burst_active   <= held_cmd.burst;
                    in_if.current_sample <= held_cmd.cur_sample;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls at random, checks each result item against the oldest due state
    always @(posedge i_clk) begin
        t_gate_state want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (due_gate_states.size() == 0) begin
                    flag_mismatch("unexpected result", 1, 0);
                end else begin
                    want = due_gate_states.pop_front();
                    if (out_if.gate_level !== want.gate_level)
                        flag_mismatch("gate_level", out_if.gate_level, want.gate_level);
                    if (out_if.gate_enable !== want.gate_enable)
                        flag_mismatch("gate_enable", out_if.gate_enable, want.gate_enable);
                    if (out_if.sweep_running !== want.sweep_running)
                        flag_mismatch("sweep_running", out_if.sweep_running,
                                      want.sweep_running);
                    if (out_if.report_valid !== want.report_valid)
                        flag_mismatch("report_valid", out_if.report_valid,
                                      want.report_valid);
                    if (out_if.report_khz !== want.report_khz)
                        flag_mismatch("report_khz", out_if.report_khz, want.report_khz);
                    if (out_if.report_current !== want.report_current)
                        flag_mismatch("report_current", out_if.report_current,
                                      want.report_current);
                    if (out_if.sweep_done !== want.sweep_done)
                        flag_mismatch("sweep_done", out_if.sweep_done, want.sweep_done);
                end
                results_n++;
            end
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic push_cmd(input logic kind, input logic [sfsg_pkg::ReqW-1:0] lo,
                            input logic [sfsg_pkg::ReqW-1:0] hi, input logic burst,
                            input logic [sfsg_pkg::SampleW-1:0] smp);
        t_sweep_cmd c;
        c.kind       = kind;
        c.min_khz    = lo;
        c.max_khz    = hi;
        c.burst      = burst;
        c.cur_sample = smp;
        pending_cmds.push_back(c);
        queued_n++;
    endtask

    // Item with every field random
    task automatic push_random();
        push_cmd(1'($urandom), sfsg_pkg::ReqW'($urandom), sfsg_pkg::ReqW'($urandom),
                 1'($urandom), sfsg_pkg::SampleW'($urandom));
    endtask

    task automatic push_tick();
        push_cmd(KIND_TICK, sfsg_pkg::ReqW'($urandom), sfsg_pkg::ReqW'($urandom),
                 1'($urandom), sfsg_pkg::SampleW'($urandom));
    endtask

    // Register write; only called while no item is in flight
    task automatic write_reg(input sfsg_pkg::t_cfg_idx idx,
                             input logic [sfsg_pkg::TickW-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            sfsg_pkg::CFG_CLOCK_HZ:         clk_rate_hz   = val[sfsg_pkg::ClkW-1:0];
            sfsg_pkg::CFG_TOGGLES_PER_STEP: toggle_target = val[sfsg_pkg::TallyW-1:0];
            sfsg_pkg::CFG_PAUSE_TICKS:      pause_len     = val;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [sfsg_pkg::TickW-1:0] hz,
                            input logic [sfsg_pkg::TickW-1:0] tog,
                            input logic [sfsg_pkg::TickW-1:0] pause);
        write_reg(sfsg_pkg::CFG_CLOCK_HZ, hz);
        write_reg(sfsg_pkg::CFG_TOGGLES_PER_STEP, tog);
        write_reg(sfsg_pkg::CFG_PAUSE_TICKS, pause);
    endtask

    // Wait until every item is taken and checked, then let the divider finish
    task automatic wait_drained();
        while (accepted_n != queued_n || due_gate_states.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Tick a running sweep towards its end so the next phase can start fresh ones
    task automatic run_out_sweep();
        int rounds;
        rounds = 0;
        wait_drained();
        while (sw_active && rounds < 2) begin
            repeat (25) push_tick();
            wait_drained();
            rounds++;
        end
    endtask

    // Mostly start-then-ticks sequences over short high-frequency ranges, some noise
    task automatic queue_sweeps(input int n);
        int left;
        int run;
        logic [sfsg_pkg::ReqW-1:0] lo;
        logic [sfsg_pkg::ReqW-1:0] hi;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 12) begin
                push_random();
                left--;
            end else begin
                lo = ($urandom_range(3) == 0) ? sfsg_pkg::ReqW'($urandom)
                                              : sfsg_pkg::ReqW'($urandom_range(999, 940));
                hi = ($urandom_range(4) == 0) ? sfsg_pkg::ReqW'($urandom)
                                              : lo + sfsg_pkg::ReqW'($urandom_range(3));
                push_cmd(KIND_START, lo, hi, ($urandom_range(9) == 0),
                         sfsg_pkg::SampleW'($urandom));
                run = $urandom_range(40, 8);
                left -= run + 1;
                repeat (run) begin
                    // the odd start mid-sweep, normally refused
                    if ($urandom_range(14) == 0)
                        push_cmd(KIND_START, sfsg_pkg::ReqW'($urandom),
                                 sfsg_pkg::ReqW'($urandom), 1'($urandom),
                                 sfsg_pkg::SampleW'($urandom));
                    else
                        push_tick();
                end
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.kind           = KIND_TICK;
        in_if.min_khz        = '0;
        in_if.max_khz        = '0;
        in_if.burst_active   = 1'b0;
        in_if.current_sample = '0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = sfsg_pkg::CFG_CLOCK_HZ;
        cfg_if.data          = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refused starts, min above max, top of range, low clamps
        src_idle_pct  = 18;
        sink_idle_pct = 52;
        set_regs(1000000, 2, 0);
        push_cmd(KIND_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);   // tick while idle
        push_cmd(KIND_START, 16'h0000, 16'h0000, 1'b1, 16'h0000);  // burst mode blocks it
        push_cmd(KIND_START, 16'hFFFF, 16'h0000, 1'b0, 16'h0000);  // 999 down to 30
        push_cmd(KIND_START, 16'd500, 16'd500, 1'b0, 16'h1234);    // already running
        push_cmd(KIND_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000);
        push_cmd(KIND_TICK, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
        push_cmd(KIND_TICK, 16'h0000, 16'h0000, 1'b0, 16'h8001);   // report, sweep ends
        push_cmd(KIND_TICK, 16'h0000, 16'h0000, 1'b0, 16'h7FFE);
        push_cmd(KIND_START, 16'd998, 16'd999, 1'b0, 16'h0000);
        repeat (6) push_tick();
        wait_drained();
        // small clock: half-period of zero, so every tick expires
        write_reg(sfsg_pkg::CFG_CLOCK_HZ, 32'd20000);
        push_cmd(KIND_START, 16'd0, 16'd0, 1'b0, 16'h5555);        // clamps to 20..30
        run_out_sweep();

        // Directed: no toggles per step, step with pause, requests above 999
        set_regs(1000000, 0, 3);
        push_cmd(KIND_START, 16'd1000, 16'd1000, 1'b0, 16'h0000);
        push_cmd(KIND_TICK, 16'h0000, 16'h0000, 1'b0, 16'hA5A5);
        push_cmd(KIND_START, 16'd998, 16'd999, 1'b0, 16'h0000);
        repeat (6) push_tick();
        run_out_sweep();

        // Random, sender idles lightly, receiver heavily
        set_regs(1000000, 1, 0);
        queue_sweeps(65);
        run_out_sweep();
        set_regs($urandom_range(3000000, 1000000), $urandom_range(6, 1), $urandom_range(12, 1));
        queue_sweeps(65);
        run_out_sweep();

        // Random, the other way round
        src_idle_pct  = 52;
        sink_idle_pct = 18;
        set_regs(1000000, $urandom_range(5, 2), 0);
        queue_sweeps(65);
        run_out_sweep();
        set_regs($urandom_range(2000000, 1000000), 1, $urandom_range(4, 0));
        queue_sweeps(65);
        run_out_sweep();

        // Random, no idling; high clock rates and the top register values last
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_regs(400000000, 1, $urandom_range(8, 0));
        queue_sweeps(65);
        wait_drained();
        set_regs({{(sfsg_pkg::TickW-sfsg_pkg::ClkW){1'b0}}, {sfsg_pkg::ClkW{1'b1}}},
                 255, 32'hFFFF_FFFF);
        queue_sweeps(45);
        wait_drained();

        if (mismatch_n == 0) begin
            $display("stepped_frequency_sweep_generator_unit regression: pass");
        end else begin
            $display("stepped_frequency_sweep_generator_unit regression: fail");
        end
        $finish;
    end

endmodule
